// ===== hdl/emrc_pkg.sv =====
// Shared types and constants for the encoder milestone round counter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package emrc_pkg;

    // Encoder geometry: one turn spans a power of two, so distances wrap for free.
    localparam int COUNTS_PER_TURN = 8192;
    localparam int POS_W           = $clog2(COUNTS_PER_TURN);
    localparam int MILESTONES      = 3;

    // Milestone offsets at 0, 1/3 and 2/3 of a turn, rounded down.
    localparam logic [POS_W-1:0] MS_OFFSET_0 = POS_W'(0);
    localparam logic [POS_W-1:0] MS_OFFSET_1 = POS_W'(COUNTS_PER_TURN / MILESTONES);
    localparam logic [POS_W-1:0] MS_OFFSET_2 = POS_W'((2 * COUNTS_PER_TURN) / MILESTONES);

    // Result field widths.
    localparam int TURN_W  = 16;
    localparam int DEPTH_W = 2;

    // Configuration port geometry: two 32-bit registers at byte offsets 0 and 4.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic CFG_START_POSITION = 1'b0;
    localparam logic CFG_NEAR_WINDOW    = 1'b1;

    localparam logic [POS_W-1:0] NEAR_WINDOW_RST = POS_W'(100);

    // Stack milestone codes.
    localparam logic [1:0] MS_ID_0 = 2'd0;
    localparam logic [1:0] MS_ID_1 = 2'd1;
    localparam logic [1:0] MS_ID_2 = 2'd2;

    // Live configuration seen by the front end.
    typedef struct packed {
        logic [POS_W-1:0] start_position;
        logic [POS_W-1:0] near_window;
    } cfg_t;

    // One classified sample: hit flag per milestone, bit i for milestone i.
    typedef logic [MILESTONES-1:0] hits_t;

endpackage : emrc_pkg

`default_nettype wire

// ===== hdl/emrc_if.sv =====
// Stream interfaces for encoder samples and counter results.
// Depends on emrc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface emrc_in_if;
    import emrc_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] encoder_position;

    modport source (output valid, output encoder_position, input ready);
    modport sink   (input valid, input encoder_position, output ready);
endinterface : emrc_in_if

interface emrc_out_if;
    import emrc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TURN_W-1:0] round_count;
    logic [DEPTH_W-1:0]       stack_depth;

    modport source (output valid, output round_count, output stack_depth, input ready);
    modport sink   (input valid, input round_count, input stack_depth, output ready);
endinterface : emrc_out_if

`default_nettype wire

// ===== hdl/emrc_cfg.sv =====
// APB-style configuration registers: start position and near window.
// Depends on emrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module emrc_cfg (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [emrc_pkg::APB_AW-1:0] paddr,
    input  wire logic [emrc_pkg::APB_DW-1:0] pwdata,
    output logic [emrc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output emrc_pkg::cfg_t                cfg
);
    import emrc_pkg::*;

    logic [POS_W-1:0] start_position_reg;
    logic [POS_W-1:0] near_window_reg;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    // Register writes on the access phase; bits above the field width are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_position_reg <= '0;
            near_window_reg    <= NEAR_WINDOW_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                CFG_START_POSITION: start_position_reg <= pwdata[POS_W-1:0];
                CFG_NEAR_WINDOW:    near_window_reg    <= pwdata[POS_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read-back mux, zero extended to the bus width.
    always_comb
    begin
        case (reg_sel)
            CFG_START_POSITION: prdata = APB_DW'(start_position_reg);
            CFG_NEAR_WINDOW:    prdata = APB_DW'(near_window_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.start_position = start_position_reg;
    assign cfg.near_window    = near_window_reg;

endmodule : emrc_cfg

`default_nettype wire

// ===== hdl/emrc_front.sv =====
// Front end: accepts encoder samples and classifies them into milestone hits.
// Depends on emrc_pkg and emrc_in_if.
`timescale 1ns / 1ps
`default_nettype none

module emrc_front (
    emrc_in_if.sink              sample,
    input  wire emrc_pkg::cfg_t  cfg,
    input  wire logic            q_full,
    output logic                 q_push,
    output emrc_pkg::hits_t      q_hits
);
    import emrc_pkg::*;

    logic [POS_W-1:0] rel_pos;
    logic [POS_W-1:0] past_0;
    logic [POS_W-1:0] past_1;
    logic [POS_W-1:0] past_2;

    // A beat is taken whenever the queue has a free slot.
    assign sample.ready = !q_full;
    assign q_push       = sample.valid & !q_full;

    // Distance from the start position; the turn is a power of two, so it wraps.
    assign rel_pos = sample.encoder_position - cfg.start_position;
    assign past_0  = rel_pos - MS_OFFSET_0;
    assign past_1  = rel_pos - MS_OFFSET_1;
    assign past_2  = rel_pos - MS_OFFSET_2;

    // A milestone is reached when the distance past it is inside the window.
    assign q_hits[0] = past_0 < cfg.near_window;
    assign q_hits[1] = past_1 < cfg.near_window;
    assign q_hits[2] = past_2 < cfg.near_window;

endmodule : emrc_front

`default_nettype wire

// ===== hdl/emrc_queue.sv =====
// Two-entry queue of classified samples between the front and back ends.
// Depends on emrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module emrc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire emrc_pkg::hits_t  push_hits,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output emrc_pkg::hits_t       pop_hits
);
    import emrc_pkg::*;

    hits_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_hits  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping; push and pop may happen in the same cycle.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots need no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_hits;
        end
    end

endmodule : emrc_queue

`default_nettype wire

// ===== hdl/emrc_back.sv =====
// Back end: milestone stack, turn counter and the registered result beat.
// Depends on emrc_pkg and emrc_out_if.
`timescale 1ns / 1ps
`default_nettype none

module emrc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_not_empty,
    input  wire emrc_pkg::hits_t  q_hits,
    output logic                  q_pop,
    emrc_out_if.source            result
);
    import emrc_pkg::*;

    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

    logic [1:0]               stack_reg [4];
    logic [1:0]               stack_next [4];
    logic [DEPTH_W-1:0]       top_reg;
    logic [DEPTH_W-1:0]       top_next;
    logic signed [TURN_W-1:0] turns_reg;
    logic signed [TURN_W-1:0] turns_next;
    logic                     out_valid_reg;
    logic signed [TURN_W-1:0] round_count_reg;
    logic [DEPTH_W-1:0]       stack_depth_reg;
    logic [1:0]               ms_id [MILESTONES];

    assign ms_id[0] = MS_ID_0;
    assign ms_id[1] = MS_ID_1;
    assign ms_id[2] = MS_ID_2;

    // Take a queued sample when the result register is empty or being drained.
    assign q_pop = q_not_empty & (!out_valid_reg | result.ready);

    // Stack update: pushes in milestone order, then back-off pop, then turn check.
    always_comb
    begin
        stack_next = stack_reg;
        top_next   = top_reg;
        turns_next = turns_reg;
        for (int m = 0; m < MILESTONES; m++)
        begin
            if (q_hits[m] && (stack_next[top_next] != ms_id[m]))
            begin
                if (top_next != 2'd3)
                begin
                    top_next = top_next + 2'd1;
                end
                stack_next[top_next] = ms_id[m];
            end
        end
        // Shaft went back over the last milestone.
        if ((top_next >= 2'd2) && (stack_next[top_next] == stack_next[top_next - 2'd2]))
        begin
            top_next = top_next - 2'd2;
        end
        // Full turn: direction comes from the first milestone after the start.
        if ((top_next == 2'd3) && (stack_next[3] == stack_next[0]))
        begin
            if (stack_next[1] == MS_ID_1)
            begin
                if (turns_reg != TURN_MAX)
                begin
                    turns_next = turns_reg + 16'sd1;
                end
            end
            else
            begin
                if (turns_reg != TURN_MIN)
                begin
                    turns_next = turns_reg - 16'sd1;
                end
            end
            top_next = 2'd0;
        end
    end

    // Counter state advances once per popped sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                stack_reg[i] <= 2'd0;
            end
            top_reg   <= '0;
            turns_reg <= '0;
        end
        else if (q_pop)
        begin
            stack_reg <= stack_next;
            top_reg   <= top_next;
            turns_reg <= turns_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            round_count_reg <= turns_next;
            stack_depth_reg <= top_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.round_count = round_count_reg;
    assign result.stack_depth = stack_depth_reg;

endmodule : emrc_back

`default_nettype wire

// ===== hdl/encoder_milestone_round_counter_top.sv =====
// Encoder milestone round counter, top level: configuration port, front end,
// queue and back end. Depends on emrc_pkg, emrc_if and the emrc_* submodules.
//
// The block takes one encoder sample per clock while the queue has room and
// returns one result beat per sample, carrying the signed turn count and the
// milestone stack depth after that sample. A sample is classified against the
// three milestones as it is accepted and parked in a two-entry queue; the back
// end pops one entry per cycle into the result register while it is empty or
// drained, a rate set by the combinational stack update. A sample passes its
// queue slot, then the result register. Samples keep flowing while a
// result waits, until the queue is full. Write the configuration only while no
// sample is in flight. The turn count saturates at its 16-bit limits.
`timescale 1ns / 1ps
`default_nettype none

module encoder_milestone_round_counter_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [emrc_pkg::APB_AW-1:0] paddr,
    input  wire logic [emrc_pkg::APB_DW-1:0] pwdata,
    output logic [emrc_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    emrc_in_if.sink                          sample,
    emrc_out_if.source                       result
);
    import emrc_pkg::*;

    cfg_t  cfg;
    logic  q_full;
    logic  q_push;
    hits_t q_push_hits;
    logic  q_pop;
    logic  q_not_empty;
    hits_t q_pop_hits;

    emrc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    emrc_front u_front (
        .sample (sample),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_hits (q_push_hits)
    );

    emrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_hits (q_push_hits),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_hits  (q_pop_hits)
    );

    emrc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_hits      (q_pop_hits),
        .q_pop       (q_pop),
        .result      (result)
    );

endmodule : encoder_milestone_round_counter_top

`default_nettype wire

// ===== hdl/emrc_checker.sv =====
// Port-level checker for the encoder milestone round counter, bound to the top.
// Depends on emrc_pkg and encoder_milestone_round_counter_top.
`timescale 1ns / 1ps
`default_nettype none

module emrc_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_ready,
    input  wire logic                             out_valid,
    input  wire logic                             out_ready,
    input  wire logic signed [emrc_pkg::TURN_W-1:0] round_count,
    input  wire logic [emrc_pkg::DEPTH_W-1:0]     stack_depth,
    input  wire logic                             pready
);
    import emrc_pkg::*;

    logic                     in_beat;
    logic                     out_beat;
    logic [1:0]               pending_reg;
    logic                     seen_reg;
    logic signed [TURN_W-1:0] last_count_reg;
    logic [TURN_W-1:0]        step_up;
    logic [TURN_W-1:0]        step_dn;

    assign in_beat  = in_valid & in_ready;
    assign out_beat = out_valid & out_ready;
    assign step_up  = TURN_W'(round_count - last_count_reg);
    assign step_dn  = TURN_W'(last_count_reg - round_count);

    // Samples accepted but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_beat) - 2'(out_beat);
        end
    end

    // Turn count of the previous delivered beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            last_count_reg <= '0;
        end
        else if (out_beat)
        begin
            seen_reg       <= 1'b1;
            last_count_reg <= round_count;
        end
    end

    // No result beat without an outstanding sample.
    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 2'd0))
        else $error("result valid with no sample outstanding");

    // A stalled result holds its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(round_count)
                                      && $stable(stack_depth)))
        else $error("stalled result changed");

    // The turn count moves by one at most, and only on a completed turn.
    a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && seen_reg && (round_count != last_count_reg))
        |-> ((stack_depth == '0) && ((step_up == TURN_W'(1)) || (step_dn == TURN_W'(1)))))
        else $error("turn count jumped or depth not cleared");

    // The configuration port never inserts wait states.
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule : emrc_checker

bind encoder_milestone_round_counter_top emrc_checker u_emrc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .round_count (result.round_count),
    .stack_depth (result.stack_depth),
    .pready      (pready)
);

`default_nettype wire

// ===== tb/encoder_milestone_round_counter_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for encoder_milestone_round_counter_top: drives encoder
// samples and register writes, predicts every result beat and compares it.
// Depends on emrc_pkg, emrc_if and the RTL of the block.

module encoder_milestone_round_counter_top_tb;
    import emrc_pkg::*;

    localparam int CYCLE_LIMIT   = 1500000;
    localparam int SETTLE_CYCLES = 4;

    // Register byte addresses: register index times four.
    localparam logic [APB_AW-1:0] START_POSITION_ADDR = {CFG_START_POSITION, 2'b00};
    localparam logic [APB_AW-1:0] NEAR_WINDOW_ADDR    = {CFG_NEAR_WINDOW, 2'b00};

    localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

    // A window just wide enough that one sample can reach two neighboring milestones.
    localparam logic [POS_W-1:0] TWO_HIT_WINDOW = MS_OFFSET_1 + POS_W'(2);

    typedef struct packed {
        logic signed [TURN_W-1:0] round_count;
        logic [DEPTH_W-1:0]       stack_depth;
    } counter_result_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    emrc_in_if  sample_if ();
    emrc_out_if result_if ();

    encoder_milestone_round_counter_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_if),
        .result  (result_if)
    );

    // Shadow of the configuration and of the milestone trail kept by the block.
    logic [POS_W-1:0]         cfg_start  = '0;
    logic [POS_W-1:0]         cfg_window = NEAR_WINDOW_RST;
    logic [1:0]               trail [4]  = '{MS_ID_0, MS_ID_0, MS_ID_0, MS_ID_0};
    logic [1:0]               trail_top  = '0;
    logic signed [TURN_W-1:0] turn_total = '0;

    counter_result_t expected_results [$];

    bit          idling_on = 1'b1;
    int unsigned stall_left;
    int          error_count;
    int          cycle_count;
    int          samples_sent;
    int          results_checked;
    int          settings_used;
    int          forward_turns;
    int          backward_turns;
    int          rollbacks;
    int          upper_limit_hits;
    int          lower_limit_hits;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Position of a milestone plus some counts, relative to the current start.
    function automatic logic [POS_W-1:0] milestone_offset(input logic [1:0] ms);
        case (ms)
            MS_ID_1: milestone_offset = MS_OFFSET_1;
            MS_ID_2: milestone_offset = MS_OFFSET_2;
            default: milestone_offset = MS_OFFSET_0;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] milestone_position(input logic [1:0] ms,
                                                            input int unsigned delta);
        return cfg_start + milestone_offset(ms) + POS_W'(delta);
    endfunction

    // Advance the shadow trail and turn count by one sample; return the result beat.
    function automatic counter_result_t advance_counter(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] rel_pos;
        logic [POS_W-1:0] past;
        logic [1:0]       ms;
        counter_result_t  res;
        rel_pos = pos - cfg_start;
        // Milestones are checked in order; each push sees the trail as updated so far.
        for (int i = 0; i < MILESTONES; i++)
        begin
            ms   = 2'(i);
            past = rel_pos - milestone_offset(ms);
            if (past < cfg_window && ms != trail[trail_top])
            begin
                if (trail_top != 2'd3)
                    trail_top = trail_top + 2'd1;
                trail[trail_top] = ms;
            end
        end
        // The shaft went back over the milestone two entries down.
        if (trail_top >= 2'd2 && trail[trail_top] == trail[trail_top - 2'd2])
        begin
            trail_top = trail_top - 2'd2;
            rollbacks++;
        end
        // Back at the first entry: one full turn, direction set by the first step.
        if (trail_top == 2'd3 && trail[3] == trail[0])
        begin
            if (trail[1] == MS_ID_1)
            begin
                forward_turns++;
                if (turn_total != TURN_MAX)
                    turn_total = turn_total + 16'sd1;
                else
                    upper_limit_hits++;
            end
            else
            begin
                backward_turns++;
                if (turn_total != TURN_MIN)
                    turn_total = turn_total - 16'sd1;
                else
                    lower_limit_hits++;
            end
            trail_top = '0;
        end
        res.round_count = turn_total;
        res.stack_depth = trail_top;
        return res;
    endfunction

    // One register write: setup phase, access phase, then idle.
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [APB_AW-1:0] addr, input logic [POS_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== APB_DW'(want))
        begin
            $display("%0t: register at 0x%0h reads wrong, expected 0x%0h, actual 0x%0h",
                     $time, addr, APB_DW'(want), prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sample stream until every predicted result beat has come back.
    task automatic drain_results();
        sample_if.valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    // Write both registers with junk in the unused upper bits, then read them back.
    task automatic set_config(input logic [POS_W-1:0] start, input logic [POS_W-1:0] window);
        drain_results();
        apb_write(START_POSITION_ADDR, ($urandom() << POS_W) | APB_DW'(start));
        apb_write(NEAR_WINDOW_ADDR, ($urandom() << POS_W) | APB_DW'(window));
        cfg_start  = start;
        cfg_window = window;
        settings_used++;
        apb_read_check(START_POSITION_ADDR, cfg_start);
        apb_read_check(NEAR_WINDOW_ADDR, cfg_window);
    endtask

    // Send one sample beat, with an optional random gap in front of it.
    task automatic send_sample(input logic [POS_W-1:0] pos);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        sample_if.valid            <= 1'b1;
        sample_if.encoder_position <= pos;
        do @(posedge clk); while (!sample_if.ready);
        expected_results.push_back(advance_counter(pos));
        samples_sent++;
    endtask

    // Compare every accepted result beat with the oldest prediction; stall at random.
    always @(posedge clk)
    begin : result_monitor
        counter_result_t want;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with none expected, actual %0d / %0d",
                             $time, result_if.round_count, result_if.stack_depth);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_if.round_count !== want.round_count)
                    begin
                        $display("%0t: round_count expected %0d, actual %0d", $time,
                                 $signed(want.round_count), result_if.round_count);
                        error_count++;
                    end
                    if (result_if.stack_depth !== want.stack_depth)
                    begin
                        $display("%0t: stack_depth expected %0d, actual %0d", $time,
                                 want.stack_depth, result_if.stack_depth);
                        error_count++;
                    end
                end
            end
            if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left != 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
            $display("encoder_milestone_round_counter_top test failed");
            $finish;
        end
    end

    task automatic test_register_defaults();
        apb_read_check(START_POSITION_ADDR, '0);
        apb_read_check(NEAR_WINDOW_ADDR, NEAR_WINDOW_RST);
    endtask

    // Reset settings: a step back, one turn each way and a miss right at the window edge.
    task automatic test_walk_directions();
        send_sample(milestone_position(MS_ID_0, 0));
        send_sample({POS_W{1'b1}});
        send_sample(milestone_position(MS_ID_1, 0));
        send_sample(milestone_position(MS_ID_0, 0));
        send_sample(milestone_position(MS_ID_1, 5));
        send_sample(milestone_position(MS_ID_2, 10));
        send_sample(milestone_position(MS_ID_0, 99));
        send_sample(milestone_position(MS_ID_2, 99));
        send_sample(milestone_position(MS_ID_1, 50));
        send_sample(milestone_position(MS_ID_0, 4));
        send_sample(milestone_position(MS_ID_0, 100));
    endtask

    // A zero window never reaches a milestone, even dead on it.
    task automatic test_zero_window();
        set_config({POS_W{1'b1}}, '0);
        send_sample(milestone_position(MS_ID_0, 0));
        send_sample(milestone_position(MS_ID_1, 0));
        send_sample(milestone_position(MS_ID_2, 0));
    endtask

    // Several milestones in one sample, including a push onto a full trail.
    task automatic test_multi_hit();
        set_config(POS_W'($urandom()), TWO_HIT_WINDOW);
        send_sample(milestone_position(MS_ID_2, 0));
        send_sample(milestone_position(MS_ID_0, 1));
        send_sample(milestone_position(MS_ID_2, 0));
        send_sample(milestone_position(MS_ID_0, MS_OFFSET_1 + 1));
        set_config(POS_W'($urandom()), {POS_W{1'b1}});
        repeat (3) send_sample(POS_W'($urandom()));
    endtask

    // Mostly a shaft walking from milestone to milestone, with reversals and noise.
    task automatic run_walk_phase(input int count);
        int unsigned cur;
        int unsigned step;
        int unsigned pick;
        int unsigned delta;
        cur  = $urandom_range(0, MILESTONES - 1);
        step = 1;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                step = MILESTONES - step;
            if (pick >= 85)
            begin
                send_sample(POS_W'($urandom_range(0, COUNTS_PER_TURN - 1)));
            end
            else
            begin
                if (pick < 78)
                    cur = (cur + step) % MILESTONES;
                if (cfg_window == '0)
                    delta = $urandom_range(0, 63);
                else if (pick % 10 == 0)
                    delta = cfg_window;
                else if (pick % 10 == 1)
                    delta = cfg_window - 1;
                else
                    delta = $urandom_range(0, cfg_window - 1);
                send_sample(milestone_position(2'(cur), delta));
            end
        end
    endtask

    task automatic test_random_traffic();
        set_config(POS_W'($urandom()), NEAR_WINDOW_RST);
        run_walk_phase(120);
        set_config({POS_W{1'b1}}, POS_W'($urandom_range(1, 400)));
        run_walk_phase(100);
        set_config(POS_W'($urandom()), '0);
        run_walk_phase(40);
        // A stretch with both sides running flat out.
        idling_on = 1'b0;
        set_config(POS_W'($urandom()), {POS_W{1'b1}});
        run_walk_phase(60);
        idling_on = 1'b1;
        set_config(POS_W'($urandom()), POS_W'($urandom_range(2000, 6000)));
        run_walk_phase(100);
        set_config('0, POS_W'($urandom_range(1, 300)));
        run_walk_phase(160);
    endtask

    // Runs of the shortest possible turns in each direction, back to back.
    task automatic test_fast_turns();
        idling_on = 1'b0;
        set_config(POS_W'($urandom()), TWO_HIT_WINDOW);
        // Backward turns need one sample per milestone.
        repeat (12)
        begin
            send_sample(milestone_position(MS_ID_2, 1000));
            send_sample(milestone_position(MS_ID_1, 1000));
            send_sample(milestone_position(MS_ID_0, 1000));
        end
        // Forward turns: one sample reaches milestones 1 and 2, the next milestone 0.
        repeat (12)
        begin
            send_sample(milestone_position(MS_ID_2, 0));
            send_sample(milestone_position(MS_ID_0, 1000));
        end
    endtask

    initial
    begin
        rst_n                      <= 1'b0;
        psel                       <= 1'b0;
        penable                    <= 1'b0;
        pwrite                     <= 1'b0;
        paddr                      <= '0;
        pwdata                     <= '0;
        sample_if.valid            <= 1'b0;
        sample_if.encoder_position <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_walk_directions();
        test_zero_window();
        test_multi_hit();
        test_random_traffic();
        test_fast_turns();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d samples under %0d register settings: %0d forward turns, %0d back",
                 samples_sent, settings_used, forward_turns, backward_turns);
        $display("%0d rollbacks, limit held %0d times high and %0d low, %0d beats, %0d errors",
                 rollbacks, upper_limit_hits, lower_limit_hits, results_checked, error_count);
        if (error_count == 0)
            $display("encoder_milestone_round_counter_top test passed");
        else
            $display("encoder_milestone_round_counter_top test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/emrc_pkg.sv
hdl/emrc_if.sv
hdl/emrc_cfg.sv
hdl/emrc_front.sv
hdl/emrc_queue.sv
hdl/emrc_back.sv
hdl/encoder_milestone_round_counter_top.sv
hdl/emrc_checker.sv
tb/encoder_milestone_round_counter_top_tb.sv
